@@ sv/glob_wildcard_matcher_assert.svh @@
// assertion macros for the glob wildcard matcher checker
// needs clk_i and rst_ni in the scope where a macro is used
`ifndef GLOB_WILDCARD_MATCHER_ASSERT_SVH
`define GLOB_WILDCARD_MATCHER_ASSERT_SVH

// clocked assertion, off while reset is applied
`define GWM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("glob matcher assertion failed");

// clocked assertion that also holds across reset
`define GWM_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("glob matcher reset assertion failed");

`endif

@@ sv/gwm_pkg.sv @@
// shared constants, types and helper functions of the glob wildcard matcher
// no dependencies
package gwm_pkg;

  localparam int PATTERN_MAX = 64;
  localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
  localparam int IDX_W       = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_APPEND = 2'd1;
  localparam logic [1:0] FUNC_TEXT   = 2'd2;
  localparam logic [1:0] FUNC_RSVD   = 2'd3;

  localparam logic [7:0] CH_STAR     = 8'h2A;
  localparam logic [7:0] CH_ONE      = 8'h3F;
  localparam logic [7:0] CH_UPPER_A  = 8'h41;
  localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_APPEND,
    OP_TEXT
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] ch;
    logic       last;
  } item_t;

  typedef logic [PATTERN_MAX:0]   pos_t;
  typedef logic [PATTERN_MAX-1:0] flag_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) r = c + CASE_OFFSET;
    return r;
  endfunction

  // spread each reached position over following stars: a carry chain where a
  // star propagates and a reached star generates
  function automatic pos_t close_stars(input pos_t pre, input flag_t star);
    pos_t x;
    pos_t g;
    pos_t s;
    x = {1'b0, star};
    g = pre & x;
    s = x + g;
    return pre | (s ^ x ^ g);
  endfunction

endpackage

@@ sv/gwm_if.sv @@
// request channels of the glob wildcard matcher: input and result
// no dependencies
interface gwm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, func, ch, last, input ready);
  modport sink (input valid, func, ch, last, output ready);
  modport monitor (input valid, ready, func, ch, last);
endinterface

interface gwm_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic pattern_overflow;

  modport source (output valid, matched, pattern_overflow, input ready);
  modport sink (input valid, matched, pattern_overflow, output ready);
  modport monitor (input valid, ready, matched, pattern_overflow);
endinterface

@@ sv/gwm_front.sv @@
// front end: accepts requests, folds case and turns func codes into queue ops
// depends on gwm_pkg and gwm_if
module gwm_front (
  gwm_in_if.sink         in_i,
  output logic           push_valid_o,
  output gwm_pkg::item_t push_item_o,
  input  logic           push_ready_i
);

  gwm_pkg::op_e op;
  logic         keep;

  always_comb begin
    op   = gwm_pkg::OP_TEXT;
    keep = 1'b1;
    unique case (in_i.func)
      gwm_pkg::FUNC_CLEAR:  op = gwm_pkg::OP_CLEAR;
      gwm_pkg::FUNC_APPEND: op = gwm_pkg::OP_APPEND;
      gwm_pkg::FUNC_TEXT:   op = gwm_pkg::OP_TEXT;
      default:              keep = 1'b0; // reserved code is swallowed
    endcase
  end

  assign in_i.ready        = push_ready_i;
  assign push_valid_o      = in_i.valid && keep;
  assign push_item_o.op    = op;
  assign push_item_o.ch    = gwm_pkg::fold_case(in_i.ch);
  assign push_item_o.last  = in_i.last;

endmodule

@@ sv/gwm_fifo.sv @@
// short queue of classified requests between front and back end
// depends on gwm_pkg
module gwm_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  input  gwm_pkg::item_t push_item_i,
  output logic           push_ready_o,
  output logic           pop_valid_o,
  output gwm_pkg::item_t pop_item_o,
  input  logic           pop_ready_i
);

  localparam logic [gwm_pkg::FIFO_PTR_W-1:0] PtrLast =
    gwm_pkg::FIFO_PTR_W'(gwm_pkg::FIFO_DEPTH - 1);
  localparam logic [gwm_pkg::FIFO_CNT_W-1:0] CntFull =
    gwm_pkg::FIFO_CNT_W'(gwm_pkg::FIFO_DEPTH);

  gwm_pkg::item_t                  mem_q [gwm_pkg::FIFO_DEPTH];
  logic [gwm_pkg::FIFO_PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [gwm_pkg::FIFO_PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [gwm_pkg::FIFO_CNT_W-1:0]  cnt_q, cnt_d;
  logic                            push, pop;

  assign push_ready_o = (cnt_q != CntFull);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    if (pop)  rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    if (push && !pop)      cnt_d = cnt_q + 1'b1;
    else if (pop && !push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_item_i;
  end

endmodule

@@ sv/gwm_back.sv @@
// back end: pattern store, bit-parallel position set and result register
// depends on gwm_pkg and gwm_if
module gwm_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  gwm_pkg::item_t q_item_i,
  output logic           q_ready_o,
  gwm_out_if.source      out_o
);

  localparam int Max = gwm_pkg::PATTERN_MAX;

  logic [7:0]                chars_q [Max];
  gwm_pkg::flag_t            star_q, star_d;
  gwm_pkg::flag_t            one_q, one_d;
  gwm_pkg::flag_t            used_q, used_d;   // thermometer of stored chars
  gwm_pkg::pos_t             end_q, end_d;     // one-hot at the pattern length
  gwm_pkg::pos_t             start_q, start_d; // start plus leading stars
  gwm_pkg::pos_t             reach_q, reach_d;
  logic [gwm_pkg::LEN_W-1:0] len_q, len_d;
  logic                      ovf_q, ovf_d;
  logic                      allstar_q, allstar_d;
  logic                      out_valid_q, out_valid_d;
  logic                      matched_q, matched_d;
  logic                      out_ovf_q, out_ovf_d;

  gwm_pkg::flag_t            eq, stay, step, live_star;
  gwm_pkg::pos_t             adv;
  logic                      take, room, is_star, wr_en;
  logic [gwm_pkg::IDX_W-1:0] wr_idx;

  assign take      = q_valid_i && (!out_valid_q || out_o.ready);
  assign q_ready_o = !out_valid_q || out_o.ready;
  assign room      = (len_q < gwm_pkg::LEN_W'(Max));
  assign is_star   = (q_item_i.ch == gwm_pkg::CH_STAR);
  assign wr_idx    = len_q[gwm_pkg::IDX_W-1:0];
  assign wr_en     = take && (q_item_i.op == gwm_pkg::OP_APPEND) && room;

  always_comb begin
    for (int i = 0; i < Max; i++) begin
      eq[i] = (chars_q[i] == q_item_i.ch);
    end
    live_star = star_q & used_q;
    stay      = reach_q[Max-1:0] & live_star;
    step      = reach_q[Max-1:0] & used_q & ~star_q & (one_q | eq);
    adv       = gwm_pkg::close_stars({1'b0, stay} | {step, 1'b0}, live_star);
  end

  always_comb begin
    star_d      = star_q;
    one_d       = one_q;
    used_d      = used_q;
    end_d       = end_q;
    start_d     = start_q;
    reach_d     = reach_q;
    len_d       = len_q;
    ovf_d       = ovf_q;
    allstar_d   = allstar_q;
    out_valid_d = out_valid_q && !out_o.ready;
    matched_d   = matched_q;
    out_ovf_d   = out_ovf_q;
    if (take) begin
      unique case (q_item_i.op)
        gwm_pkg::OP_CLEAR: begin
          used_d    = '0;
          end_d     = gwm_pkg::pos_t'(1);
          start_d   = gwm_pkg::pos_t'(1);
          reach_d   = gwm_pkg::pos_t'(1);
          len_d     = '0;
          ovf_d     = 1'b0;
          allstar_d = 1'b1;
        end
        gwm_pkg::OP_APPEND: begin
          if (room) begin
            star_d[wr_idx] = is_star;
            one_d[wr_idx]  = (q_item_i.ch == gwm_pkg::CH_ONE);
            used_d[wr_idx] = 1'b1;
            end_d          = end_q << 1;
            len_d          = len_q + 1'b1;
            allstar_d      = allstar_q && is_star;
            if (allstar_q && is_star) start_d = start_q | (end_q << 1);
          end else begin
            ovf_d = 1'b1;
          end
          reach_d = start_d;
        end
        gwm_pkg::OP_TEXT: begin
          if (q_item_i.last) begin
            reach_d     = start_q;
            out_valid_d = 1'b1;
            matched_d   = !used_q[0] || |(adv & end_q);
            out_ovf_d   = ovf_q;
          end else begin
            reach_d = adv;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      end_q       <= gwm_pkg::pos_t'(1);
      start_q     <= gwm_pkg::pos_t'(1);
      reach_q     <= gwm_pkg::pos_t'(1);
      len_q       <= '0;
      ovf_q       <= 1'b0;
      allstar_q   <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      used_q      <= used_d;
      end_q       <= end_d;
      start_q     <= start_d;
      reach_q     <= reach_d;
      len_q       <= len_d;
      ovf_q       <= ovf_d;
      allstar_q   <= allstar_d;
      out_valid_q <= out_valid_d;
    end
  end

  // pattern and result payload, no reset; pattern bits are only read where the used mask is set
  always_ff @(posedge clk_i) begin
    star_q    <= star_d;
    one_q     <= one_d;
    matched_q <= matched_d;
    out_ovf_q <= out_ovf_d;
    if (wr_en) chars_q[wr_idx] <= q_item_i.ch;
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.matched          = matched_q;
  assign out_o.pattern_overflow = out_ovf_q;

endmodule

@@ sv/glob_wildcard_matcher.sv @@
// Case-insensitive whole-string glob matcher ('?' one char, '*' any run).
// One request is taken per clock cycle with no bubbles while the output
// sink is ready: the position set of all 64 pattern places advances
// bit-parallel with each text character, so the sustained rate is set by the
// back end's update. A result is held in the output register after its final
// text character is taken. A two-entry queue between front and back end
// takes up to two more requests while a result waits at the output register.
// Top level; depends on gwm_pkg, gwm_if, gwm_front, gwm_fifo and gwm_back.
module glob_wildcard_matcher (
  input  logic      clk_i,
  input  logic      rst_ni,
  gwm_in_if.sink    in_i,
  gwm_out_if.source out_o
);

  logic           push_valid, push_ready;
  gwm_pkg::item_t push_item;
  logic           pop_valid, pop_ready;
  gwm_pkg::item_t pop_item;

  gwm_front u_front (
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_item_o  (push_item),
    .push_ready_i (push_ready)
  );

  gwm_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_item_i  (push_item),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_item_o   (pop_item),
    .pop_ready_i  (pop_ready)
  );

  gwm_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (pop_valid),
    .q_item_i  (pop_item),
    .q_ready_o (pop_ready),
    .out_o     (out_o)
  );

endmodule

@@ sv/gwm_checker.sv @@
// port-level checker for the glob wildcard matcher, bound to the top level
// depends on glob_wildcard_matcher_assert.svh
`include "glob_wildcard_matcher_assert.svh"

module gwm_port_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic matched_i,
  input logic overflow_i
);

  // a stalled result keeps its valid and payload
  `GWM_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i)
  `GWM_ASSERT(a_out_stable, out_valid_i && !out_ready_i |=> $stable({matched_i, overflow_i}))
  // the back end drains a queue entry whenever the sink is ready
  `GWM_ASSERT(a_in_ready_after_drain, out_ready_i |=> in_ready_i)
  // no result can leave in the cycle after reset
  `GWM_ASSERT_RST(a_no_result_after_reset, !rst_ni |=> !out_valid_i)

endmodule

bind glob_wildcard_matcher gwm_port_checker u_gwm_port_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .matched_i   (out_o.matched),
  .overflow_i  (out_o.pattern_overflow)
);

@@ tb/gwm_checker.sv @@
`timescale 1ns / 100ps
// checker of the glob wildcard matcher: watches both request channels, predicts verdicts
// depends on gwm_pkg and gwm_if
module gwm_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  gwm_in_if.monitor  in_i,
  gwm_out_if.monitor out_i,
  output int         fail_count_o,
  output int         pending_o
);

  typedef struct packed {
    logic matched;
    logic overflow;
  } verdict_t;

  verdict_t      verdicts_q [$];
  logic [7:0]    glob_bytes [gwm_pkg::PATTERN_MAX];
  int unsigned   glob_len;
  logic          glob_dropped;
  gwm_pkg::pos_t live_pos;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    if (c >= gwm_pkg::CH_UPPER_A && c <= gwm_pkg::CH_UPPER_Z)
      return c + gwm_pkg::CASE_OFFSET;
    return c;
  endfunction

  // a reached star also reaches the place after it, chains walk forward
  function automatic gwm_pkg::pos_t spread_stars(input gwm_pkg::pos_t s);
    gwm_pkg::pos_t r;
    r = s;
    for (int i = 0; i < glob_len; i++)
      if (r[i] && glob_bytes[i] == gwm_pkg::CH_STAR) r[i+1] = 1'b1;
    return r;
  endfunction

  function automatic gwm_pkg::pos_t start_pos();
    gwm_pkg::pos_t s;
    s = '0;
    s[0] = 1'b1;
    return spread_stars(s);
  endfunction

  function automatic gwm_pkg::pos_t step_pos(input gwm_pkg::pos_t cur, input logic [7:0] c);
    gwm_pkg::pos_t nxt;
    nxt = '0;
    for (int i = 0; i < glob_len; i++) begin
      if (cur[i]) begin
        if (glob_bytes[i] == gwm_pkg::CH_STAR) nxt[i] = 1'b1;
        else if (glob_bytes[i] == gwm_pkg::CH_ONE || glob_bytes[i] == c)
          nxt[i+1] = 1'b1;
      end
    end
    return spread_stars(nxt);
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count_o++;
  endtask

  task automatic predict_request(input logic [1:0] f, input logic [7:0] c_raw, input logic l);
    logic [7:0] c;
    verdict_t   v;
    c = to_lower(c_raw);
    case (f)
      gwm_pkg::FUNC_CLEAR: begin
        glob_len     = 0;
        glob_dropped = 1'b0;
        live_pos     = start_pos();
      end
      gwm_pkg::FUNC_APPEND: begin
        if (glob_len < gwm_pkg::PATTERN_MAX) begin
          glob_bytes[glob_len] = c;
          glob_len++;
        end else begin
          glob_dropped = 1'b1;
        end
        live_pos = start_pos();
      end
      gwm_pkg::FUNC_TEXT: begin
        live_pos = step_pos(live_pos, c);
        if (l) begin
          v.matched  = (glob_len == 0) ? 1'b1 : live_pos[glob_len];
          v.overflow = glob_dropped;
          verdicts_q.push_back(v);
          live_pos = start_pos();
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t v;
    if (!rst_ni) begin
      verdicts_q.delete();
      glob_len     = 0;
      glob_dropped = 1'b0;
      live_pos     = '0;
      live_pos[0]  = 1'b1;
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      // results first: a result never belongs to a request taken at the same edge
      if (out_i.valid && out_i.ready) begin
        if (verdicts_q.size() == 0) begin
          report_mismatch($sformatf("result m=%b o=%b with none pending",
                                    out_i.matched, out_i.pattern_overflow));
        end else begin
          v = verdicts_q.pop_front();
          if (out_i.matched !== v.matched)
            report_mismatch($sformatf("matched %b, predicted %b", out_i.matched, v.matched));
          if (out_i.pattern_overflow !== v.overflow)
            report_mismatch($sformatf("pattern_overflow %b, predicted %b",
                                      out_i.pattern_overflow, v.overflow));
        end
      end
      if (in_i.valid && in_i.ready) predict_request(in_i.func, in_i.ch, in_i.last);
      pending_o = verdicts_q.size();
    end
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// top of the glob wildcard matcher testbench: clock, reset, stimulus and verdict
// depends on gwm_pkg, gwm_if, glob_wildcard_matcher and gwm_checker
module testbench;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int REQS_PER_PASS = 450;

  typedef logic [7:0] byte_q_t [$];

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   cycle_count;
  int   send_idle_pct;
  int   stall_pct;
  int   counted_reqs;
  byte_q_t kept_glob;

  gwm_in_if  in_ch ();
  gwm_out_if out_ch ();

  glob_wildcard_matcher i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  gwm_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_ch),
    .out_i        (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic logic [7:0] alpha_char();
    case ($urandom_range(3))
      0: return "a";
      1: return "b";
      2: return "A";
      default: return "B";
    endcase
  endfunction

  function automatic logic [7:0] text_char();
    int r;
    r = $urandom_range(99);
    if (r < 50) return alpha_char();
    if (r < 60) return gwm_pkg::CH_STAR;
    if (r < 65) return gwm_pkg::CH_ONE;
    if (r < 70) return 8'h00;
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] glob_char();
    int r;
    r = $urandom_range(99);
    if (r < 30) return gwm_pkg::CH_STAR;
    if (r < 45) return gwm_pkg::CH_ONE;
    if (r < 80) return alpha_char();
    if (r < 85) return 8'h00;
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] flip_case(input logic [7:0] c);
    if (c >= gwm_pkg::CH_UPPER_A && c <= gwm_pkg::CH_UPPER_Z)
      return c + gwm_pkg::CASE_OFFSET;
    if (c >= gwm_pkg::CH_UPPER_A + gwm_pkg::CASE_OFFSET &&
        c <= gwm_pkg::CH_UPPER_Z + gwm_pkg::CASE_OFFSET)
      return c - gwm_pkg::CASE_OFFSET;
    return c;
  endfunction

  // text built to follow the stored pattern, then sometimes spoiled
  function automatic byte_q_t derive_text();
    byte_q_t t;
    int      k;
    foreach (kept_glob[i]) begin
      if (kept_glob[i] == gwm_pkg::CH_STAR) begin
        repeat ($urandom_range(3)) t.push_back(text_char());
      end else if (kept_glob[i] == gwm_pkg::CH_ONE) begin
        t.push_back(text_char());
      end else begin
        t.push_back($urandom_range(1) ? flip_case(kept_glob[i]) : kept_glob[i]);
      end
    end
    if ($urandom_range(99) < 30) begin
      if (t.size() == 0) begin
        t.push_back(text_char());
      end else begin
        k = $urandom_range(t.size() - 1);
        case ($urandom_range(2))
          0: t[k] = text_char();
          1: t.delete(k);
          default: t.push_back(text_char());
        endcase
      end
    end
    if (t.size() == 0) t.push_back(text_char());
    return t;
  endfunction

  // called at a falling edge, returns at the falling edge after the request is taken
  task automatic send_req(input logic [1:0] f, input logic [7:0] c, input logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.func  <= f;
    in_ch.ch    <= c;
    in_ch.last  <= l;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    if (f != gwm_pkg::FUNC_RSVD) counted_reqs++;
    if (f == gwm_pkg::FUNC_CLEAR) kept_glob.delete();
    if (f == gwm_pkg::FUNC_APPEND && kept_glob.size() < gwm_pkg::PATTERN_MAX)
      kept_glob.push_back(c);
  endtask

  task automatic send_text(input byte_q_t t);
    foreach (t[i]) send_req(gwm_pkg::FUNC_TEXT, t[i], i == t.size() - 1);
  endtask

  task automatic send_glob(input int n);
    send_req(gwm_pkg::FUNC_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)));
    repeat (n) send_req(gwm_pkg::FUNC_APPEND, glob_char(), 1'($urandom_range(1)));
  endtask

  task automatic random_text();
    byte_q_t t;
    if ($urandom_range(99) < 70) begin
      t = derive_text();
    end else begin
      repeat ($urandom_range(1, 6)) t.push_back(text_char());
    end
    send_text(t);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic directed_part();
    send_req(gwm_pkg::FUNC_TEXT, 8'h00, 1'b1);          // empty pattern matches
    send_req(gwm_pkg::FUNC_RSVD, 8'hFF, 1'b1);          // unused code, ignored
    send_req(gwm_pkg::FUNC_APPEND, "A", 1'b0);
    send_req(gwm_pkg::FUNC_APPEND, gwm_pkg::CH_ONE, 1'b0);
    send_req(gwm_pkg::FUNC_APPEND, gwm_pkg::CH_STAR, 1'b1);
    send_req(gwm_pkg::FUNC_TEXT, "a", 1'b0);
    send_req(gwm_pkg::FUNC_TEXT, "Z", 1'b0);
    send_req(gwm_pkg::FUNC_TEXT, gwm_pkg::CH_STAR, 1'b1); // literal star in text
    send_req(gwm_pkg::FUNC_TEXT, "a", 1'b1);
    send_req(gwm_pkg::FUNC_APPEND, 8'h00, 1'b0);
    send_req(gwm_pkg::FUNC_TEXT, "A", 1'b0);
    send_req(gwm_pkg::FUNC_TEXT, 8'hFF, 1'b0);
    send_req(gwm_pkg::FUNC_TEXT, 8'h00, 1'b1);
    send_req(gwm_pkg::FUNC_TEXT, "a", 1'b0);
    send_req(gwm_pkg::FUNC_CLEAR, 8'hFF, 1'b1);         // abandons text in progress
    send_req(gwm_pkg::FUNC_APPEND, "[", 1'b0);
    send_req(gwm_pkg::FUNC_TEXT, "{", 1'b1);            // just past the fold range
    send_req(gwm_pkg::FUNC_APPEND, "z", 1'b0);
    send_req(gwm_pkg::FUNC_TEXT, "[", 1'b0);
    send_req(gwm_pkg::FUNC_TEXT, "Z", 1'b1);
    send_req(gwm_pkg::FUNC_APPEND, gwm_pkg::CH_STAR, 1'b0);
    send_req(gwm_pkg::FUNC_TEXT, "[", 1'b0);
    send_req(gwm_pkg::FUNC_TEXT, "z", 1'b1);
    send_req(gwm_pkg::FUNC_TEXT, "@", 1'b1);
  endtask

  task automatic random_part();
    int r;
    int n;
    int seq;
    seq = 0;
    while (counted_reqs < REQS_PER_PASS) begin
      r = $urandom_range(99);
      if (r < 70 || seq == 0) begin
        n = $urandom_range(99);
        if (seq == 0 || n < 3)
          send_glob($urandom_range(gwm_pkg::PATTERN_MAX + 1, gwm_pkg::PATTERN_MAX + 8));
        else if (n < 10) send_glob($urandom_range(9, gwm_pkg::PATTERN_MAX));
        else send_glob($urandom_range(8));
        repeat ($urandom_range(1, 4)) random_text();
      end else if (r < 85) begin
        repeat ($urandom_range(1, 3)) random_text();
      end else if (r < 95) begin
        repeat ($urandom_range(1, 6))
          send_req(2'($urandom_range(3)), 8'($urandom_range(255)), 1'($urandom_range(1)));
      end else begin
        // text cut short by a pattern change
        repeat ($urandom_range(1, 3)) send_req(gwm_pkg::FUNC_TEXT, text_char(), 1'b0);
        if ($urandom_range(1)) send_req(gwm_pkg::FUNC_CLEAR, 8'($urandom_range(255)), 1'b0);
        else send_req(gwm_pkg::FUNC_APPEND, glob_char(), 1'b0);
      end
      seq++;
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.func    = gwm_pkg::FUNC_CLEAR;
    in_ch.ch      = 8'h00;
    in_ch.last    = 1'b0;
    out_ch.ready  = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    cycle_count   = 0;
    counted_reqs  = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    for (int pass = 0; pass < 4; pass++) begin
      case (pass)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 82; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 82; end
        default: begin send_idle_pct = 19; stall_pct = 19; end
      endcase
      counted_reqs = 0;
      if (pass == 0) directed_part();
      random_part();
      // sender holds off until every pending verdict is back
      wait_drained();
    end
    repeat (10) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
